FILE: hdl/bur_pkg.sv
// Shared types and constants of the bounded uniform random block.
package bur_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned SeedW = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SEED_LOW = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEED_HIGH = 2'd1;

  localparam logic [SeedW-1:0] SEED_LOW_RESET = 64'd1;
  localparam logic [SeedW-1:0] SEED_HIGH_RESET = 64'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_MUL,
    ST_CHECK,
    ST_MOD_WAIT,
    ST_TEST,
    ST_REDRAW,
    ST_REMUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_limit;
    logic draw;
    logic mul;
    logic mod_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic low_lt_limit;
    logic low_lt_residue;
    logic state_zero;
    logic mod_done;
    logic out_busy;
  } status_t;

endpackage

FILE: hdl/bounded_uniform_random.sv
// Top level of the bounded uniform random block.
// Fast path: a word is accepted, drawn, multiplied and checked; the result is
// loaded for output once the previous output word is taken, and a new word is
// accepted only after that load. A low product word below the limit adds a run of
// the bit-serial residue unit and a test, and each resample a draw and a multiply.
// Reset loads seed_low with 1 and seed_high with 0, so generator word 0 is 1.
module bounded_uniform_random
  import bur_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SeedW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [WordW-1:0]   limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WordW-1:0]   value_o
);

  cmd_t    cmd;
  status_t status;

  bur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bur_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .limit_i     (limit_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .value_o     (value_o)
  );

endmodule

FILE: hdl/bur_mod.sv
// Bit-serial restoring unit that computes (2^32 - divisor) mod divisor.
module bur_mod
  import bur_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] divisor_i,
  output logic             done_o,
  output logic [WordW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(WordW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] num_q, num_d;
  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[WordW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = WordW'(0) - divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = WordW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[WordW-1:0];
      end
      num_d = {num_q[WordW-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: hdl/bur_dp.sv
// Datapath: generator state, seed registers, multiplier, residue unit and output word.
module bur_dp
  import bur_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SeedW-1:0]   cfg_data_i,
  input  logic [WordW-1:0]   limit_i,
  input  logic               out_ready_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic               out_valid_o,
  output logic [WordW-1:0]   value_o
);

  logic [SeedW-1:0]   seed_low_q, seed_low_d;
  logic [SeedW-1:0]   seed_high_q, seed_high_d;
  logic [WordW-1:0]   gen_q [4];
  logic [WordW-1:0]   gen_d [4];
  logic [WordW-1:0]   limit_q;
  logic [WordW-1:0]   word_q;
  logic [2*WordW-1:0] prod_q;
  logic [WordW-1:0]   value_q;
  logic               out_valid_q, out_valid_d;
  logic [WordW-1:0]   mul5, rot7, draw_out, shifted, s2, s3;
  logic [WordW-1:0]   residue;
  logic               mod_done;

  bur_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_start),
    .divisor_i (limit_q),
    .done_o    (mod_done),
    .rem_o     (residue)
  );

  always_comb begin
    mul5     = gen_q[0] + {gen_q[0][WordW-3:0], 2'b00};
    rot7     = {mul5[WordW-8:0], mul5[WordW-1:WordW-7]};
    draw_out = rot7 + {rot7[WordW-4:0], 3'b000};
    shifted  = {gen_q[1][WordW-10:0], 9'd0};
    s2       = gen_q[2] ^ gen_q[0];
    s3       = gen_q[3] ^ gen_q[1];
  end

  always_comb begin
    seed_low_d  = seed_low_q;
    seed_high_d = seed_high_q;
    gen_d       = gen_q;
    if (cfg_we_i && (cfg_index_i == CFG_SEED_LOW || cfg_index_i == CFG_SEED_HIGH)) begin
      if (cfg_index_i == CFG_SEED_LOW) begin
        seed_low_d = cfg_data_i;
      end else begin
        seed_high_d = cfg_data_i;
      end
      gen_d[0] = seed_low_d[WordW-1:0];
      gen_d[1] = seed_low_d[SeedW-1:WordW];
      gen_d[2] = seed_high_d[WordW-1:0];
      gen_d[3] = seed_high_d[SeedW-1:WordW];
    end else if (cmd_i.draw) begin
      gen_d[0] = gen_q[0] ^ s3;
      gen_d[1] = gen_q[1] ^ s2;
      gen_d[2] = s2 ^ shifted;
      gen_d[3] = {s3[WordW-12:0], s3[WordW-1:WordW-11]};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_low_q  <= SEED_LOW_RESET;
      seed_high_q <= SEED_HIGH_RESET;
      gen_q[0]    <= SEED_LOW_RESET[WordW-1:0];
      gen_q[1]    <= SEED_LOW_RESET[SeedW-1:WordW];
      gen_q[2]    <= SEED_HIGH_RESET[WordW-1:0];
      gen_q[3]    <= SEED_HIGH_RESET[SeedW-1:WordW];
      out_valid_q <= 1'b0;
    end else begin
      seed_low_q  <= seed_low_d;
      seed_high_q <= seed_high_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_limit) begin
      limit_q <= limit_i;
    end
    if (cmd_i.draw) begin
      word_q <= draw_out;
    end
    if (cmd_i.mul) begin
      prod_q <= word_q * limit_q;
    end
    if (cmd_i.load_out) begin
      value_q <= prod_q[2*WordW-1:WordW];
    end
  end

  assign status_o.low_lt_limit   = prod_q[WordW-1:0] < limit_q;
  assign status_o.low_lt_residue = prod_q[WordW-1:0] < residue;
  assign status_o.state_zero     = (gen_q[0] | gen_q[1] | gen_q[2] | gen_q[3]) == '0;
  assign status_o.mod_done       = mod_done;
  assign status_o.out_busy       = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("Output word overwritten before it was taken.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && limit_q != '0) |-> (prod_q[2*WordW-1:WordW] < limit_q))
    else $error("Result word is not below the limit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> $past(cmd_i.draw))
    else $error("Multiply issued without a fresh draw.");

endmodule

FILE: hdl/bur_ctrl.sv
// Controller state machine that sequences draw, multiply, residue and resampling.
module bur_ctrl
  import bur_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DRAW;
      end
      ST_DRAW:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.low_lt_limit) begin
          state_d = ST_MOD_WAIT;
        end else if (status_i.out_busy) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD_WAIT: begin
        if (status_i.mod_done) state_d = ST_TEST;
      end
      ST_TEST: begin
        if (status_i.low_lt_residue && !status_i.state_zero) begin
          state_d = ST_REDRAW;
        end else if (status_i.out_busy) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REDRAW: state_d = ST_REMUL;
      ST_REMUL:  state_d = ST_TEST;
      ST_OUT: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_limit = accept;
    unique case (state_q)
      ST_DRAW, ST_REDRAW: cmd_o.draw = 1'b1;
      ST_MUL, ST_REMUL:   cmd_o.mul = 1'b1;
      ST_CHECK: begin
        cmd_o.mod_start = status_i.low_lt_limit;
        cmd_o.load_out  = !status_i.low_lt_limit && !status_i.out_busy;
      end
      ST_TEST: begin
        cmd_o.load_out = !(status_i.low_lt_residue && !status_i.state_zero) &&
                         !status_i.out_busy;
      end
      ST_OUT:   cmd_o.load_out = !status_i.out_busy;
      default:  cmd_o = cmd_o;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

FILE: sim/bounded_uniform_random_tb.sv
// Self-checking testbench for the bounded uniform random block.
`timescale 1ns / 1ps

module bounded_uniform_random_tb;
  import bur_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PhaseItems = 205;
  localparam int unsigned SettleCycles = 12;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_B = 2'd3;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_RUNS,
    RX_PATTERN
  } rx_mode_e;

  // Tracks the generator and the seed registers, and keeps the values still owed.
  class bounded_draw_model;
    logic [SeedW-1:0]      seed_lo;
    logic [SeedW-1:0]      seed_hi;
    logic [3:0][WordW-1:0] xs;
    logic [WordW-1:0]      expected_values[$];
    int                    errors;

    function new();
      seed_lo = SEED_LOW_RESET;
      seed_hi = SEED_HIGH_RESET;
      xs = {seed_hi, seed_lo};
      errors = 0;
    endfunction

    function logic [WordW-1:0] rotl(logic [WordW-1:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function logic [WordW-1:0] next_word();
      logic [WordW-1:0] word;
      logic [WordW-1:0] shifted;
      word = rotl(xs[0] * 32'd5, 7) * 32'd9;
      shifted = xs[1] << 9;
      xs[2] = xs[2] ^ xs[0];
      xs[3] = xs[3] ^ xs[1];
      xs[1] = xs[1] ^ xs[2];
      xs[0] = xs[0] ^ xs[3];
      xs[2] = xs[2] ^ shifted;
      xs[3] = rotl(xs[3], 11);
      return word;
    endfunction

    function void load_seed(logic [CfgIdxW-1:0] idx, logic [SeedW-1:0] data);
      if (idx == CFG_SEED_LOW) begin
        seed_lo = data;
      end else if (idx == CFG_SEED_HIGH) begin
        seed_hi = data;
      end else begin
        return;
      end
      xs = {seed_hi, seed_lo};
    endfunction

    function void take_limit(logic [WordW-1:0] lim);
      logic [63:0]      prod;
      logic [WordW-1:0] residue;
      prod = {32'd0, next_word()} * {32'd0, lim};
      if (prod[31:0] < lim) begin
        residue = (32'd0 - lim) % lim;
        // A generator stuck at zero would reject forever, so the product is taken.
        while (prod[31:0] < residue && xs != '0) begin
          prod = {32'd0, next_word()} * {32'd0, lim};
        end
      end
      expected_values.push_back(prod[63:32]);
    endfunction

    function void check_value(logic [WordW-1:0] got);
      logic [WordW-1:0] want;
      if (expected_values.size() == 0) begin
        $error("value: expected none, actual %08h", got);
        errors++;
        return;
      end
      want = expected_values.pop_front();
      if (got !== want) begin
        $error("value: expected %08h, actual %08h", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [SeedW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [WordW-1:0]   limit_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [WordW-1:0]   value_o;

  bounded_draw_model sb;
  rx_mode_e          rx_mode = RX_ALWAYS;
  int                run_left = 0;
  logic [7:0]        stall_pat = 8'b1101_1010;
  int unsigned       cycle_count = 0;

  logic [WordW-1:0] corner_limits [16] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
    32'h8000_0001, 32'h8000_0001, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h0000_0007, 32'hC000_0001, 32'h0000_0000
  };

  logic [WordW-1:0] stuck_limits [7] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0003, 32'h8000_0001,
    32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0005
  };

  bounded_uniform_random dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .limit_i    (limit_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_value(value_o);
    end
    case (rx_mode)
      RX_ALWAYS: out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_RUNS: begin
        if (run_left != 0) begin
          run_left <= run_left - 1;
        end else begin
          out_ready_i <= ~out_ready_i;
          run_left <= $urandom_range(0, 12);
        end
      end
      default: begin
        out_ready_i <= stall_pat[0];
        stall_pat <= {stall_pat[0], stall_pat[7:1]};
      end
    endcase
  end

  function automatic logic [SeedW-1:0] rand_seed();
    return {$urandom(), $urandom()};
  endfunction

  // Near 2^31 the rejection rate is about one half, so resampling runs deep.
  function automatic logic [WordW-1:0] rand_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return $urandom_range(1, 16);
      3: return 32'd1 << $urandom_range(0, 31);
      4, 5: return 32'h8000_0000 + $urandom_range(1, 64);
      6: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [SeedW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.load_seed(idx, data);
  endtask

  task automatic send_word(input logic [WordW-1:0] lim);
    in_valid_i <= 1'b1;
    limit_i <= lim;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_limit(lim);
  endtask

  task automatic send_random(input int n, input bit gaps);
    int burst;
    int k;
    burst = 0;
    for (k = 0; k < n; k++) begin
      if (gaps && burst <= 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 45 : 6)) @(posedge clk_i);
        burst = $urandom_range(1, 20);
      end
      send_word(rand_limit());
      burst--;
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int p;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rx_mode <= RX_RANDOM;
    foreach (corner_limits[i]) send_word(corner_limits[i]);
    settle();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_cfg(CFG_SEED_LOW, '1);
          write_cfg(CFG_SEED_HIGH, '1);
        end
        1: begin
          write_cfg(CFG_SEED_LOW, '0);
          write_cfg(CFG_SEED_HIGH, '0);
        end
        2: begin
          write_cfg(CFG_SEED_LOW, rand_seed());
          write_cfg(CFG_SEED_HIGH, rand_seed());
          write_cfg(CFG_UNUSED_A, rand_seed());
        end
        3: begin
          write_cfg(CFG_UNUSED_B, '1);
          write_cfg(CFG_SEED_HIGH, rand_seed());
        end
        4: begin
          write_cfg(CFG_SEED_LOW, '0);
          write_cfg(CFG_SEED_HIGH, 64'd1);
        end
        5: write_cfg(CFG_SEED_LOW, 64'h8000_0000_0000_0000);
        6: begin
          write_cfg(CFG_UNUSED_A, '0);
          write_cfg(CFG_UNUSED_B, rand_seed());
        end
        default: begin
          write_cfg(CFG_SEED_HIGH, rand_seed());
          write_cfg(CFG_SEED_LOW, rand_seed());
        end
      endcase
      cfg_we_i <= 1'b0;
      rx_mode <= rx_mode_e'(p % 4);
      @(posedge clk_i);
      if (p == 1) begin
        // With an all-zero generator every draw is zero and rejection must give up.
        foreach (stuck_limits[i]) send_word(stuck_limits[i]);
        send_random(10, 1'b1);
      end else begin
        send_random(PhaseItems, p != 4);
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bur_pkg.sv
hdl/bur_mod.sv
hdl/bur_dp.sv
hdl/bur_ctrl.sv
hdl/bounded_uniform_random.sv
sim/bounded_uniform_random_tb.sv
